[hdl/cmap4_pkg.sv]
`default_nettype none
package cmap4_pkg;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned GID_W  = 16;
    localparam int unsigned LEN_W  = 17;
    localparam logic [15:0] CP_MAX = 16'hFFFF;
    localparam int unsigned HDR_W  = 14;

    localparam logic [1:0] REG_BASE    = 2'd0;
    localparam logic [1:0] REG_LENGTH  = 2'd1;
    localparam logic [1:0] REG_PRESENT = 2'd2;

    typedef enum logic [0:0] {
        ACT_WRITE  = 1'b0,
        ACT_LOOKUP = 1'b1
    } t_action;

    // queue entry between front and back
    typedef struct packed {
        t_action     action;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [CP_W-1:0] cp;
    } t_cmd;

    typedef struct packed {
        logic [15:0] base;
        logic [LEN_W-1:0] length;
        logic        present;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_RD_LEN,
        ST_RD_X2,
        ST_SRCH,
        ST_RD_END,
        ST_RD_START,
        ST_RD_DELTA,
        ST_RD_RANGE,
        ST_RD_GID,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

[hdl/cmap4_ram.sv]
`default_nettype none
module cmap4_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hdl/cmap4_front.sv]
`default_nettype none
module cmap4_front
    import cmap4_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    output logic       o_full,
    input  wire t_cmd  i_cmd,
    output logic       o_valid,
    input  wire        i_take,
    output t_cmd       o_cmd
);
    // two-entry queue between the input side and the sequencer
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_in, w_out;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_in    = i_push && !o_full;
    assign w_out   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) r_wp <= ~r_wp;
            if (w_out) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in) r_q[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

[hdl/cmap4_back.sv]
`default_nettype none
module cmap4_back
    import cmap4_pkg::*;
#(
    parameter int unsigned MEM_BYTES    = 65536,
    parameter int unsigned MAX_SEGMENTS = 10000
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire        i_valid,
    input  wire t_cmd  i_cmd,
    output logic       o_take,
    output logic       o_res_valid,
    output logic [GID_W-1:0] o_res,
    input  wire        i_res_ready
);
    localparam int unsigned AW = $clog2(MEM_BYTES);
    localparam int unsigned XW = 36; // wide offsets, never wrap

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [XW-1:0] r_addr, n_addr;
    logic          r_phase, n_phase;
    logic [7:0]    r_hi, n_hi;
    logic [15:0]   r_x2, n_x2;
    logic [15:0]   r_lo, n_lo, r_hn, n_hn;
    logic [15:0]   r_start, n_start, r_delta, n_delta;
    logic [GID_W-1:0] r_res, n_res;
    logic [GID_W-1:0] r_out, n_out;
    logic          r_rv, n_rv;
    logic [7:0]    w_rd;
    logic [15:0]   w_word;
    logic          w_ok;
    logic [XW-1:0] w_base, w_ends, w_starts, w_deltas, w_ranges, w_lo2;
    logic [XW-1:0] w_addr;
    logic [15:0]   w_mid;
    logic [AW-1:0] w_raddr;
    logic          w_we;

    assign w_base   = XW'(i_cfg.base);
    assign w_ends   = w_base + XW'(HDR_W);
    assign w_starts = w_ends + XW'(r_x2) + XW'(2);
    assign w_deltas = w_starts + XW'(r_x2);
    assign w_ranges = w_deltas + XW'(r_x2);
    assign w_lo2    = XW'({r_lo, 1'b0});
    assign w_mid    = 16'((17'(r_lo) + 17'(r_hn)) >> 1);
    // drop the latch-cycle flag from the word address
    assign w_addr   = {1'b0, r_addr[XW-2:0]};
    assign w_raddr  = AW'(w_addr + XW'(r_phase));
    assign w_word   = {r_hi, w_rd};
    assign w_ok     = (w_addr + XW'(2) <= XW'(i_cfg.length))
                   && (w_addr + XW'(2) <= XW'(MEM_BYTES));
    assign w_we     = (r_state == ST_WRITE) && (XW'(r_cmd.addr) < XW'(MEM_BYTES));

    cmap4_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(AW'(r_cmd.addr)),
        .i_wdata(r_cmd.data),
        .i_raddr(w_raddr),
        .o_rdata(w_rd)
    );

    assign o_take      = (r_state == ST_IDLE);
    assign o_res_valid = r_rv;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rv    <= n_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) r_cmd <= i_cmd;
        r_addr <= n_addr; r_phase <= n_phase; r_hi <= n_hi; r_x2 <= n_x2;
        r_lo <= n_lo; r_hn <= n_hn; r_start <= n_start; r_delta <= n_delta;
        r_res <= n_res; r_out <= n_out;
    end

    // each word read: issue byte 0, issue byte 1 / latch byte 0, latch byte 1
    always_comb begin
        logic [15:0] cp16;
        logic        word_rdy;
        logic [XW-1:0] gaddr;
        n_state = r_state; n_addr = r_addr; n_phase = r_phase; n_hi = r_hi;
        n_x2 = r_x2; n_lo = r_lo; n_hn = r_hn; n_start = r_start;
        n_delta = r_delta; n_res = r_res; n_rv = r_rv; n_out = r_out;
        cp16 = r_cmd.cp[15:0];
        word_rdy = 1'b0;
        gaddr = '0;
        if (r_rv && i_res_ready) n_rv = 1'b0;
        if (r_state != ST_IDLE && r_state != ST_WRITE && r_state != ST_DONE) begin
            if (!w_ok) begin
                n_res = '0; n_state = ST_DONE;
            end else if (!r_phase) begin
                n_phase = 1'b1;
            end else begin
                n_hi = w_rd; // first latch then word on next
                word_rdy = 1'b0;
            end
        end
        case (r_state)
            ST_IDLE: begin
                if (o_take && i_valid) begin
                    if (i_cmd.action == ACT_WRITE) begin
                        n_state = ST_WRITE;
                    end else if (!i_cfg.present || i_cmd.cp > CP_W'(CP_MAX)) begin
                        n_res = '0; n_state = ST_DONE;
                    end else begin
                        n_addr = w_base + XW'(2); n_phase = 1'b0; n_state = ST_RD_LEN;
                    end
                end
            end
            ST_WRITE: n_state = ST_IDLE;
            ST_DONE: begin
                // hold the finished result until the output register is free
                if (!r_rv) begin
                    n_rv = 1'b1; n_out = r_res; n_state = ST_IDLE;
                end
            end
            default: ;
        endcase
        // word completes in the cycle after phase 1 (second byte on rd port)
        if (r_state != ST_IDLE && r_state != ST_WRITE && r_state != ST_DONE
            && w_ok && r_phase && r_addr[XW-1]) begin
            word_rdy = 1'b1;
        end
        // r_addr msb flags the latch cycle of a word
        if (r_state != ST_IDLE && r_state != ST_WRITE && r_state != ST_DONE
            && r_addr[XW-1]) begin
            n_hi = r_hi;
            n_phase = 1'b0;
            n_addr = r_addr;
            case (r_state)
                ST_RD_LEN: begin
                    if (w_base + XW'(w_word) > XW'(i_cfg.length)) begin
                        n_res = '0; n_state = ST_DONE;
                    end else begin
                        n_addr = w_base + XW'(6); n_state = ST_RD_X2;
                    end
                end
                ST_RD_X2: begin
                    n_x2 = w_word;
                    if (w_word[15:1] == 15'd0 || 32'(w_word[15:1]) > MAX_SEGMENTS) begin
                        n_res = '0; n_state = ST_DONE;
                    end else begin
                        n_lo = '0; n_hn = {1'b0, w_word[15:1]};
                        n_addr = w_base + XW'(HDR_W)
                               + XW'({(17'({1'b0, w_word[15:1]}) >> 1), 1'b0});
                        n_state = ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    if (w_word < cp16) n_lo = w_mid + 16'd1;
                    else n_hn = w_mid;
                    if (((w_word < cp16) ? w_mid + 16'd1 : r_lo)
                        >= ((w_word < cp16) ? r_hn : w_mid)) begin
                        if (((w_word < cp16) ? w_mid + 16'd1 : r_lo) >= {1'b0, r_x2[15:1]})
                        begin
                            n_res = '0; n_state = ST_DONE;
                        end else begin
                            n_addr = w_ends + XW'({((w_word < cp16) ? w_mid + 16'd1 : r_lo),
                                                   1'b0});
                            n_state = ST_RD_END;
                        end
                    end else begin
                        n_addr = w_ends + XW'({16'((17'((w_word < cp16) ? w_mid + 16'd1
                                  : r_lo) + 17'((w_word < cp16) ? r_hn : w_mid)) >> 1),
                                  1'b0});
                        n_state = ST_SRCH;
                    end
                end
                ST_RD_END: begin
                    n_addr = w_starts + w_lo2; n_state = ST_RD_START;
                end
                ST_RD_START: begin
                    n_start = w_word; n_addr = w_deltas + w_lo2; n_state = ST_RD_DELTA;
                end
                ST_RD_DELTA: begin
                    n_delta = w_word; n_addr = w_ranges + w_lo2; n_state = ST_RD_RANGE;
                end
                ST_RD_RANGE: begin
                    gaddr = w_ranges + w_lo2 + XW'(w_word) + XW'({cp16 - r_start, 1'b0});
                    if (cp16 < r_start) begin
                        n_res = '0; n_state = ST_DONE;
                    end else if (w_word == 16'd0) begin
                        n_res = cp16 + r_delta; n_state = ST_DONE;
                    end else begin
                        n_addr = gaddr; n_state = ST_RD_GID;
                    end
                end
                ST_RD_GID: begin
                    n_res = (w_word == 16'd0) ? 16'd0 : w_word + r_delta;
                    n_state = ST_DONE;
                end
                default: ;
            endcase
            n_addr[XW-1] = 1'b0;
        end else if (r_state != ST_IDLE && r_state != ST_WRITE && r_state != ST_DONE
                     && w_ok && r_phase) begin
            n_addr[XW-1] = 1'b1; // next cycle second byte is on the port
        end
        if (word_rdy) n_hi = r_hi;
    end
endmodule
`default_nettype wire

[hdl/cmap_format4_glyph_lookup_top.sv]
`default_nettype none
// A write reaches the font memory from the sequencer's write state. A lookup result
// is built from 16-bit reads over the single byte port (two header reads, up to 14
// search probes, four segment reads, one glyph read). One item is carried out at a
// time: a write or a lookup holds the sequencer until it is done, and a two-entry
// queue buffers input beats. Reset clears control state and the configuration
// registers; font memory is undefined until written.
module cmap_format4_glyph_lookup_top
    import cmap4_pkg::*;
#(
    parameter int unsigned MEM_BYTES    = 65536,
    parameter int unsigned MAX_SEGMENTS = 10000
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [1:0]        i_cfg_index,
    input  wire [LEN_W-1:0]  i_cfg_data,
    input  wire              push,
    output logic             full,
    input  wire              i_action,
    input  wire [15:0]       i_byte_address,
    input  wire [7:0]        i_byte_value,
    input  wire [CP_W-1:0]   i_code_point,
    output logic             empty,
    input  wire              pop,
    output logic [GID_W-1:0] o_glyph_index
);
    t_cfg r_cfg;
    t_cmd w_in, w_q;
    logic w_qv, w_take, w_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BASE:    r_cfg.base    <= i_cfg_data[15:0];
                REG_LENGTH:  r_cfg.length  <= i_cfg_data;
                REG_PRESENT: r_cfg.present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_in = '{action: t_action'(i_action), addr: i_byte_address,
                    data: i_byte_value, cp: i_code_point};

    cmap4_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_cmd(w_in), .o_valid(w_qv), .i_take(w_take), .o_cmd(w_q)
    );

    cmap4_back #(.MEM_BYTES(MEM_BYTES), .MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_valid(w_qv),
        .i_cmd(w_q), .o_take(w_take), .o_res_valid(w_rv), .o_res(o_glyph_index),
        .i_res_ready(pop)
    );

    assign empty = !w_rv;
endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top
    import cmap4_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_CYCLES    = 300;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_index;
    logic [LEN_W-1:0] i_cfg_data;
    logic             push;
    logic             full;
    t_action          i_action;
    logic [15:0]      i_byte_address;
    logic [7:0]       i_byte_value;
    logic [CP_W-1:0]  i_code_point;
    logic             empty;
    logic             pop;
    logic [GID_W-1:0] o_glyph_index;

    cmap_format4_glyph_lookup_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_action       (i_action),
        .i_byte_address (i_byte_address),
        .i_byte_value   (i_byte_value),
        .i_code_point   (i_code_point),
        .empty          (empty),
        .pop            (pop),
        .o_glyph_index  (o_glyph_index)
    );

    // shadow of the font memory and the registers
    logic [7:0]  font_mem [0:65535];
    bit          font_written [0:65535];
    int          shadow_base;
    int          shadow_length;
    bit          shadow_present;
    bit          unwritten_hit;

    logic [15:0] glyph_q [$];
    int          seg_lo [$];
    int          seg_hi [$];

    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_pop;
    int          err_count;
    int          quiet_cycles;
    int          n_writes;
    int          n_lookups;
    int          n_checked;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
        $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
        err_count++;
    endtask

    // big-endian word read with the same bounds rules as the block
    function automatic bit read_word(longint a, output logic [15:0] v);
        v = '0;
        if (a + 2 > shadow_length) return 1'b0;
        if (a + 2 > 65536) return 1'b0;
        if (!font_written[a] || !font_written[a + 1]) unwritten_hit = 1'b1;
        v = {font_mem[a], font_mem[a + 1]};
        return 1'b1;
    endfunction

    function automatic logic [15:0] predict_glyph(logic [CP_W-1:0] cp);
        longint      b, ends, starts, deltas, ranges;
        logic [15:0] sublen, x2, v, st, dl, ro, gid;
        int          segs, lo, hi, mid;
        if (!shadow_present || cp > CP_W'(CP_MAX)) return 16'h0;
        b = shadow_base;
        if (!read_word(b + 2, sublen)) return 16'h0;
        if (b + sublen > shadow_length) return 16'h0;
        if (!read_word(b + 6, x2)) return 16'h0;
        segs = x2 / 2;
        if (segs == 0 || segs > 10000) return 16'h0;
        ends   = b + HDR_W;
        starts = ends + x2 + 2;
        deltas = starts + x2;
        ranges = deltas + x2;
        lo = 0;
        hi = segs;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (!read_word(ends + mid * 2, v)) return 16'h0;
            if (v < cp) lo = mid + 1;
            else hi = mid;
        end
        if (lo >= segs) return 16'h0;
        if (!read_word(ends + lo * 2, v)) return 16'h0;
        if (!read_word(starts + lo * 2, st)) return 16'h0;
        if (!read_word(deltas + lo * 2, dl)) return 16'h0;
        if (!read_word(ranges + lo * 2, ro)) return 16'h0;
        if (cp < st) return 16'h0;
        if (ro == 0) return cp[15:0] + dl;
        if (!read_word(ranges + lo * 2 + ro + (longint'(cp) - st) * 2, gid)) return 16'h0;
        if (gid == 0) return 16'h0;
        return gid + dl;
    endfunction

    // hold push high across back-to-back beats; only lower it for a gap
    task automatic send_item(t_action a, logic [15:0] ad, logic [7:0] v, logic [CP_W-1:0] cp);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_action       <= a;
        i_byte_address <= ad;
        i_byte_value   <= v;
        i_code_point   <= cp;
        do @(posedge i_clk); while (full);
    endtask

    task automatic send_write(logic [15:0] ad, logic [7:0] v);
        send_item(ACT_WRITE, ad, v, CP_W'($urandom));
        font_mem[ad]     = v;
        font_written[ad] = 1'b1;
        n_writes++;
    endtask

    task automatic send_lookup(logic [CP_W-1:0] cp);
        logic [15:0] g;
        unwritten_hit = 1'b0;
        g = predict_glyph(cp);
        // steer away from reads of bytes never written
        if (unwritten_hit) begin
            cp = '1;
            g  = 16'h0;
        end
        send_item(ACT_LOOKUP, 16'($urandom), 8'($urandom), cp);
        glyph_q.push_back(g);
        n_lookups++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (glyph_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= LEN_W'(val);
        @(posedge i_clk);
        case (idx)
            REG_BASE:    shadow_base    = val & 16'hFFFF;
            REG_LENGTH:  shadow_length  = val & 17'h1FFFF;
            REG_PRESENT: shadow_present = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(int b, int len, bit pres);
        drain();
        cfg_write(REG_BASE, b);
        cfg_write(REG_LENGTH, len);
        cfg_write(REG_PRESENT, pres);
        i_cfg_we <= 1'b0;
    endtask

    // lay out a format 4 subtable at b; modes 1 to 5 damage the header
    task automatic build_table(int b, int nseg, int mode, output int tlen);
        logic [7:0] img [$];
        int x2, cur, st, en, gpos, gcount, rpos, roff;
        int starts_a [$];
        int ends_a [$];
        bit use_range [$];
        x2 = 2 * nseg;
        seg_lo.delete();
        seg_hi.delete();
        cur = $urandom_range(0, 200);
        gcount = 0;
        for (int i = 0; i < nseg; i++) begin
            use_range.push_back(i != nseg - 1 && $urandom_range(1) == 1);
            if (i == nseg - 1) begin
                st = (cur > 16'hFFFF) ? 16'hFFFF : cur;
                if ($urandom_range(1)) st = 16'hFFFF;
                en = 16'hFFFF;
            end else begin
                st = cur + $urandom_range(0, 500);
                en = st + (use_range[i] ? $urandom_range(0, 7) : $urandom_range(0, 2000));
                cur = en + 1;
            end
            starts_a.push_back(st);
            ends_a.push_back(en);
            seg_lo.push_back(st);
            seg_hi.push_back(en);
            if (use_range[i]) gcount += en - st + 1;
        end
        gpos = 16 + 4 * x2;
        tlen = gpos + 2 * gcount;
        for (int k = 0; k < tlen; k++) img.push_back(8'($urandom));
        img[0] = 8'h00;
        img[1] = 8'h04;
        {img[2], img[3]} = 16'(tlen);
        {img[6], img[7]} = 16'(x2);
        {img[HDR_W + x2], img[HDR_W + x2 + 1]} = 16'h0;
        gcount = 0;
        for (int i = 0; i < nseg; i++) begin
            {img[HDR_W + 2*i], img[HDR_W + 2*i + 1]} = 16'(ends_a[i]);
            {img[HDR_W + x2 + 2 + 2*i], img[HDR_W + x2 + 3 + 2*i]} = 16'(starts_a[i]);
            rpos = HDR_W + 3 * x2 + 2 + 2 * i;
            roff = use_range[i] ? gpos + 2 * gcount - rpos : 0;
            {img[rpos], img[rpos + 1]} = 16'(roff);
            if (use_range[i]) begin
                for (int k = 0; k <= ends_a[i] - starts_a[i]; k++) begin
                    // drop some entries to zero to hit the missing-glyph path
                    if ($urandom_range(5) == 0) begin
                        img[gpos + 2*(gcount + k)]     = 8'h0;
                        img[gpos + 2*(gcount + k) + 1] = 8'h0;
                    end
                end
                gcount += ends_a[i] - starts_a[i] + 1;
            end
        end
        case (mode)
            1: {img[6], img[7]} = 16'(x2 + 1);
            2: {img[6], img[7]} = 16'h0;
            3: {img[6], img[7]} = 16'd20002;
            4: {img[2], img[3]} = 16'hFFFF;
            5: {img[6], img[7]} = 16'd20000;
            default: ;
        endcase
        for (int k = 0; k < tlen && b + k <= 16'hFFFF; k++) send_write(16'(b + k), img[k]);
    endtask

    function automatic logic [CP_W-1:0] pick_cp();
        int r, i;
        r = $urandom_range(99);
        if (r < 65 && seg_lo.size() != 0) begin
            i = $urandom_range(seg_lo.size() - 1);
            case ($urandom_range(3))
                0: return CP_W'(seg_lo[i] - 1);
                1: return CP_W'(seg_hi[i] + 1);
                default: return CP_W'(seg_lo[i] + $urandom_range(0, seg_hi[i] - seg_lo[i]));
            endcase
        end
        if (r < 85) return CP_W'($urandom_range(0, 16'hFFFF));
        return CP_W'($urandom);
    endfunction

    task automatic test_directed();
        int tlen;
        set_config(0, 0, 1'b0);
        send_lookup('0);
        send_lookup(CP_W'(16'h0041));
        send_write(16'hFFFF, 8'hFF);
        send_write(16'h0000, 8'h00);
        build_table(0, 4, 0, tlen);
        set_config(0, tlen, 1'b1);
        send_lookup('0);
        send_lookup(CP_W'(CP_MAX));
        send_lookup(CP_W'(32'h10000));
        send_lookup(CP_W'(32'h10FFFF));
        send_lookup('1);
        for (int i = 0; i < seg_lo.size(); i++) begin
            send_lookup(CP_W'(seg_lo[i]));
            send_lookup(CP_W'(seg_hi[i]));
            send_lookup(CP_W'(seg_lo[i] - 1));
        end
        // one byte short of the table
        set_config(0, tlen - 1, 1'b1);
        send_lookup(CP_W'(seg_lo[0]));
        set_config(16'hFFFF, 17'h10000, 1'b1);
        send_lookup(CP_W'(16'h0020));
        set_config(0, 0, 1'b1);
        send_lookup(CP_W'(seg_lo[0]));
    endtask

    task automatic test_bad_headers();
        int tlen;
        for (int m = 1; m <= 5; m++) begin
            set_config(0, 0, 1'b0);
            build_table(16'h2000, 3, m, tlen);
            set_config(16'h2000, 16'h2000 + tlen + 32, 1'b1);
            for (int k = 0; k < 6; k++) send_lookup(pick_cp());
        end
    endtask

    task automatic test_top_of_memory();
        int tlen;
        set_config(0, 0, 1'b0);
        build_table(16'hFF00, 3, 0, tlen);
        set_config(16'hFF00, 17'h10000, 1'b1);
        for (int k = 0; k < 30; k++) send_lookup(pick_cp());
    endtask

    task automatic test_random(int items, int s_pct, int r_pct);
        int b, tlen, len, sel;
        set_config(0, 0, 1'b0);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        b = $urandom_range(0, 16'hE000);
        build_table(b, $urandom_range(1, 10), ($urandom_range(9) == 0) ? $urandom_range(1, 5) : 0,
                    tlen);
        sel = $urandom_range(9);
        if (sel < 6) len = b + tlen;
        else if (sel < 8) len = 17'h10000;
        else len = b + tlen - $urandom_range(0, 20);
        set_config(b, len, $urandom_range(19) != 0);
        for (int k = 0; k < items; k++) begin
            sel = $urandom_range(99);
            if (sel < 85) send_lookup(pick_cp());
            else if (sel < 95) send_write(16'($urandom), 8'($urandom));
            else send_write(16'(b + $urandom_range(0, tlen - 1)), 8'($urandom));
        end
    endtask

    task automatic test_backpressure();
        int tlen;
        set_config(0, 0, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        build_table(16'h4000, 6, 0, tlen);
        set_config(16'h4000, 16'h4000 + tlen, 1'b1);
        fork
            begin
                hold_pop = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_pop = 1'b0;
            end
        join_none
        for (int k = 0; k < 40; k++) send_lookup(pick_cp());
        drain();
        for (int k = 0; k < 20; k++) send_lookup(pick_cp());
    endtask

    // result check, pop driver and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles <= ((push && !full) || (pop && !empty)) ? 0 : quiet_cycles + 1;
            if (pop && !empty) begin
                if (glyph_q.size() == 0) begin
                    report_mismatch("unexpected beat", 16'h0, o_glyph_index);
                end else begin
                    if (o_glyph_index !== glyph_q[0])
                        report_mismatch("glyph_index", glyph_q[0], o_glyph_index);
                    void'(glyph_q.pop_front());
                    n_checked++;
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
        pop <= hold_pop ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_BASE;
        i_cfg_data     = '0;
        push           = 1'b0;
        pop            = 1'b0;
        i_action       = ACT_WRITE;
        i_byte_address = '0;
        i_byte_value   = '0;
        i_code_point   = '0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_pop       = 1'b0;
        err_count      = 0;
        quiet_cycles   = 0;
        n_writes       = 0;
        n_lookups      = 0;
        n_checked      = 0;
        shadow_base    = 0;
        shadow_length  = 0;
        shadow_present = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_bad_headers();
        test_top_of_memory();
        test_random(210, 0, 0);
        test_random(210, 61, 0);
        test_random(210, 0, 61);
        test_random(210, 20, 20);
        test_backpressure();
        drain();

        $display("covered %0d byte writes and %0d lookups, %0d results checked",
                 n_writes, n_lookups, n_checked);
        $display("tables: normal, damaged headers, top of memory, truncated length, stalls");
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", err_count);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
hdl/cmap4_pkg.sv
hdl/cmap4_ram.sv
hdl/cmap4_front.sv
hdl/cmap4_back.sv
hdl/cmap_format4_glyph_lookup_top.sv
tb/tb_top.sv
